// ===== design/ils_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg
// Shared sizes, codes and the command word that is broadcast to every cell of
// the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Storage geometry
  localparam int DEPTH       = 64;
  localparam int ENTRY_WIDTH = 32;

  // Fixed port widths
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int FIDX_W = 7;
  localparam int LEN_W  = 7;
  localparam int ST_W   = 3;

  // Derived widths
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Match scan: lanes are examined one group per cycle
  localparam int GRP_SIZE = 8;
  localparam int GRP_BITS = $clog2(GRP_SIZE);
  localparam int NGRP     = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int MATCH_W  = NGRP * GRP_SIZE;

  typedef logic [ENTRY_WIDTH-1:0] entry_t;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_INSERT    = 3'd1,
    OP_DELETE    = 3'd2,
    OP_OVERWRITE = 3'd3,
    OP_SEARCH    = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE
  } cell_op_e;

  // Broadcast to all cells each cycle
  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   pos;
    logic [CNT_W-1:0]   fill;
    entry_t             val;
  } cell_cmd_t;

  // Scan unit report
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } scan_res_t;

endpackage : ils_pkg
`default_nettype wire

// ===== design/ils_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_cell
// One list entry. Loads a new value, takes its lower or upper neighbor on an
// insert or delete shift, and compares itself against the broadcast value.
// ----------------------------------------------------------------------------
module ils_cell
  import ils_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_cmd_t        cmd,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire entry_t           below_entry,
  input  wire entry_t           above_entry,
  output entry_t                entry,
  output entry_t                tap,
  output logic                  hit
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   at_pos;
  logic   above_pos;

  assign at_pos    = (cell_idx == cmd.pos);
  assign above_pos = (cell_idx > cmd.pos);

  // Pick the next entry value from the broadcast command
  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.op)
      CELL_HOLD:   entry_nxt = entry_r;
      CELL_INSERT: begin
        if (at_pos) entry_nxt = cmd.val;
        else if (above_pos) entry_nxt = below_entry;
      end
      CELL_DELETE: begin
        if (at_pos || above_pos) entry_nxt = above_entry;
      end
      CELL_WRITE: begin
        if (at_pos) entry_nxt = cmd.val;
      end
      default:     entry_nxt = entry_r;
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

  // Drive the read tap only from the addressed cell
  assign tap = at_pos ? entry_r : '0;

  // Match only inside the filled part of the list
  assign hit = (CNT_W'(cell_idx) < cmd.fill) && (entry_r == cmd.val);

endmodule : ils_cell
`default_nettype wire

// ===== design/ils_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_scan
// First-match finder. Captures the match lanes of all cells, then walks them
// one group of lanes per cycle from the bottom of the list.
// ----------------------------------------------------------------------------
module ils_scan
  import ils_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [MATCH_W-1:0] match,
  output scan_res_t               res
);

  logic               busy_r;
  logic [GRP_W-1:0]   grp_r;
  logic [MATCH_W-1:0] match_r;
  logic [GRP_SIZE-1:0] grp_bits;
  logic [GRP_BITS-1:0] pri;
  logic               grp_any;
  logic               last_grp;
  logic [GRP_W+GRP_BITS-1:0] full_idx;

  assign grp_bits = match_r[grp_r * GRP_SIZE +: GRP_SIZE];
  assign grp_any  = |grp_bits;
  assign last_grp = (grp_r == GRP_W'(NGRP - 1));

  // Lowest set lane inside the current group
  always_comb begin
    pri = '0;
    for (int b = GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) pri = GRP_BITS'(b);
    end
  end

  assign full_idx = {grp_r, pri};

  assign res.done = busy_r && (grp_any || last_grp);
  assign res.hit  = grp_any;
  assign res.idx  = IDX_W'(full_idx);

  // Capture lanes on start, advance one group per cycle, stop on a hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      grp_r  <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      grp_r   <= '0;
      match_r <= match;
    end else if (busy_r) begin
      if (grp_any || last_grp) busy_r <= 1'b0;
      else grp_r <= grp_r + GRP_W'(1);
    end
  end

endmodule : ils_scan
`default_nettype wire

// ===== design/indexed_list_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list with a fill count, held in a row of shifting cells. Supports
// read, insert, delete, overwrite, first-match search and clear.
// ----------------------------------------------------------------------------
// Sequence: a transaction is accepted in S_IDLE, resolved in S_EXEC and
//   moved to the output register from S_DONE; a search passes through S_SCAN,
//   where the scan unit walks the match lanes one group of 8 per cycle.
// Flow: one transaction at a time; the next is taken once the result is in
//   the output register, so an output stall also holds up the input.
// Reset: synchronous, active low; clears the fill count and all handshake
//   state. Entry contents are not reset.
module indexed_list_store
  import ils_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_opcode,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic [DATA_W-1:0] in_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_data,
  output logic [FIDX_W-1:0]      out_found_index,
  output logic [LEN_W-1:0]       out_length,
  output logic [ST_W-1:0]        out_status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_e;

  state_e             state_r;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   fill_nxt;
  op_e                op_r;
  logic [POS_W-1:0]   pos_r;
  entry_t             val_r;

  logic [DATA_W-1:0]  res_data_r;
  logic [FIDX_W-1:0]  res_found_r;
  logic [LEN_W-1:0]   res_len_r;
  logic [ST_W-1:0]    res_status_r;

  logic               out_valid_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [FIDX_W-1:0]  out_found_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [ST_W-1:0]    out_status_r;

  cell_cmd_t          cmd;
  cell_op_e           exec_cell_op;
  status_e            exec_status;
  logic [DATA_W-1:0]  exec_data;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   fill_x;

  entry_t             cell_entry [DEPTH];
  entry_t             cell_tap   [DEPTH];
  logic [MATCH_W-1:0] match;
  entry_t             tap_or;

  logic               in_fire;
  logic               out_free;
  logic               scan_start;
  scan_res_t          scan_res;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign scan_start = (state_r == S_EXEC) && (op_r == OP_SEARCH);

  assign pos_x  = CMP_W'(pos_r);
  assign fill_x = CMP_W'(fill_r);

  // OR together the read taps; only the addressed cell drives one
  always_comb begin
    tap_or = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tap_or = tap_or | cell_tap[k];
    end
  end

  // Decide the operation outcome from the fill count and position
  always_comb begin
    exec_cell_op = CELL_HOLD;
    exec_status  = ST_OK;
    exec_data    = '0;
    fill_nxt     = fill_r;
    case (op_r)
      OP_READ, OP_DELETE, OP_OVERWRITE: begin
        if (fill_r == '0) begin
          exec_status = ST_EMPTY;
        end else if (pos_x >= fill_x) begin
          exec_status = ST_RANGE;
        end else if (op_r == OP_READ) begin
          exec_data = DATA_W'(tap_or);
        end else if (op_r == OP_DELETE) begin
          exec_data    = DATA_W'(tap_or);
          exec_cell_op = CELL_DELETE;
          fill_nxt     = fill_r - CNT_W'(1);
        end else begin
          exec_data    = DATA_W'(val_r);
          exec_cell_op = CELL_WRITE;
        end
      end
      OP_INSERT: begin
        if (fill_r == CNT_W'(DEPTH)) begin
          exec_status = ST_FULL;
        end else if (pos_x > fill_x) begin
          exec_status = ST_RANGE;
        end else begin
          exec_data    = DATA_W'(val_r);
          exec_cell_op = CELL_INSERT;
          fill_nxt     = fill_r + CNT_W'(1);
        end
      end
      OP_CLEAR: fill_nxt = '0;
      default: ;
    endcase
  end

  // Broadcast command: shift only in the execute cycle
  always_comb begin
    cmd.op   = (state_r == S_EXEC) ? exec_cell_op : CELL_HOLD;
    cmd.pos  = IDX_W'(pos_r);
    cmd.fill = fill_r;
    cmd.val  = val_r;
  end

  // Row of cells, each linked to its two neighbors
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    entry_t below_w;
    entry_t above_w;
    logic   hit_w;

    if (k == 0) begin : g_bot
      assign below_w = '0;
    end else begin : g_mid_lo
      assign below_w = cell_entry[k-1];
    end

    if (k == DEPTH - 1) begin : g_top
      assign above_w = '0;
    end else begin : g_mid_hi
      assign above_w = cell_entry[k+1];
    end

    ils_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cell_idx    (IDX_W'(k)),
      .below_entry (below_w),
      .above_entry (above_w),
      .entry       (cell_entry[k]),
      .tap         (cell_tap[k]),
      .hit         (hit_w)
    );

    assign match[k] = hit_w;
  end

  // Pad lanes past the last cell never match
  if (MATCH_W > DEPTH) begin : g_pad
    assign match[MATCH_W-1:DEPTH] = '0;
  end

  ils_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .match (match),
    .res   (scan_res)
  );

  // Sequencer, fill count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the taken result unless a new one loads in this cycle
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= op_e'(in_opcode);
            pos_r   <= in_position;
            val_r   <= ENTRY_WIDTH'(in_value);
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          fill_r       <= fill_nxt;
          res_data_r   <= exec_data;
          res_found_r  <= '1;
          res_len_r    <= LEN_W'(fill_nxt);
          res_status_r <= exec_status;
          state_r      <= (op_r == OP_SEARCH) ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          if (scan_res.done) begin
            if (scan_res.hit) begin
              res_found_r  <= FIDX_W'(scan_res.idx);
              res_status_r <= ST_OK;
            end else begin
              res_found_r  <= '1;
              res_status_r <= ST_NOTFOUND;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= res_data_r;
            out_found_r  <= res_found_r;
            out_len_r    <= res_len_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign out_found_index = out_found_r;
  assign out_length      = out_len_r;
  assign out_status      = out_status_r;

  // Fill count never passes the list depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // A failed search reports no index
  a_notfound_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NOTFOUND) |-> (out_found_index == '1))
    else $error("not-found result with an index");

  // A full rejection reports a full list
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_length == LEN_W'(DEPTH)))
    else $error("full status with short list");

  // An accepted transaction blocks the input until it completes
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

endmodule : indexed_list_store
`default_nettype wire
